// ----- hw/rtl/dpf_pkg.sv -----
// Shared types and constants for the demand paging frame manager.
// No dependencies.
package dpf_pkg;

	localparam int DIV_W   = 17;
	localparam int FIELD_W = 16;

	typedef enum logic [1:0] {
		KIND_ALLOC   = 2'd0,
		KIND_RELEASE = 2'd1,
		KIND_READ    = 2'd2,
		KIND_WRITE   = 2'd3
	} dpf_kind_t;

	localparam logic REG_FRAME_SIZE = 1'b0;
	localparam logic REG_FRAMES     = 1'b1;

	localparam logic [16:0] FSIZE_RESET  = 17'd16;
	localparam logic [6:0]  FRAMES_RESET = 7'd64;
	localparam logic [16:0] MSIZE_MAX    = 17'd65536;

	// Broadcast command seen by every cell in the chain.
	typedef struct packed {
		logic               free_en;
		logic               map_en;
		logic [FIELD_W-1:0] owner;
		logic [FIELD_W-1:0] vpage;
	} dpf_cmd_t;

endpackage

// ----- hw/rtl/dpf_cell.sv -----
// One frame table entry of the rotating cell chain.
// Depends on dpf_pkg.
module dpf_cell #(
	parameter int IW        = 6,
	parameter int RW        = 7,
	parameter int RESET_TAG = 0
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   shift,
	input  logic                   nb_busy,
	input  logic [IW-1:0]          nb_tag,
	input  logic [15:0]            nb_owner,
	input  logic [15:0]            nb_vpage,
	input  logic [RW-1:0]          nb_rank,
	input  dpf_pkg::dpf_cmd_t      cmd,
	input  logic [IW-1:0]          free_tag,
	input  logic [RW-1:0]          free_rank,
	input  logic [IW-1:0]          map_tag,
	input  logic [RW-1:0]          map_rank,
	output logic                   busy,
	output logic [IW-1:0]          tag,
	output logic [15:0]            owner,
	output logic [15:0]            vpage,
	output logic [RW-1:0]          rank
);
	import dpf_pkg::*;

	logic          busy_q, src_busy, nx_busy;
	logic [IW-1:0] tag_q, src_tag;
	logic [15:0]   owner_q, vpage_q, src_owner, src_vpage, nx_owner, nx_vpage;
	logic [RW-1:0] rank_q, src_rank, nx_rank;

	always_comb begin
		src_busy  = shift ? nb_busy  : busy_q;
		src_tag   = shift ? nb_tag   : tag_q;
		src_owner = shift ? nb_owner : owner_q;
		src_vpage = shift ? nb_vpage : vpage_q;
		src_rank  = shift ? nb_rank  : rank_q;
		nx_busy  = src_busy;
		nx_owner = src_owner;
		nx_vpage = src_vpage;
		nx_rank  = src_rank;
		if (cmd.free_en) begin
			if (src_tag == free_tag) begin
				nx_busy = 1'b0;
			end else if (src_busy && src_rank > free_rank) begin
				nx_rank = src_rank - 1'b1;
			end
		end
		if (cmd.map_en && src_tag == map_tag) begin
			nx_busy  = 1'b1;
			nx_owner = cmd.owner;
			nx_vpage = cmd.vpage;
			nx_rank  = map_rank;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			tag_q  <= IW'(RESET_TAG);
		end else begin
			busy_q <= nx_busy;
			tag_q  <= src_tag;
		end
	end

	always_ff @(posedge clk) begin
		owner_q <= nx_owner;
		vpage_q <= nx_vpage;
		rank_q  <= nx_rank;
	end

	assign busy  = busy_q;
	assign tag   = tag_q;
	assign owner = owner_q;
	assign vpage = vpage_q;
	assign rank  = rank_q;

endmodule

// ----- hw/rtl/dpf_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Depends on dpf_pkg.
module dpf_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [dpf_pkg::DIV_W-1:0] dividend,
	input  logic [dpf_pkg::DIV_W-1:0] divisor,
	output logic                      done,
	output logic [dpf_pkg::DIV_W-1:0] quo,
	output logic [dpf_pkg::DIV_W-1:0] rem
);
	import dpf_pkg::*;

	localparam int CW = $clog2(DIV_W + 1);

	logic [CW-1:0]    cnt_q;
	logic             run_q, done_q;
	logic [DIV_W-1:0] quo_q, dsr_q;
	logic [DIV_W:0]   rem_q, trial;

	assign trial = {rem_q[DIV_W-1:0], quo_q[DIV_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DIV_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			if (trial >= {1'b0, dsr_q}) begin
				rem_q <= trial - {1'b0, dsr_q};
				quo_q <= {quo_q[DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[DIV_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q[DIV_W-1:0];

endmodule

// ----- hw/rtl/demand_paging_fifo_frame_manager.sv -----
// Frame manager top: item control, config registers, rotating frame table.
// Depends on dpf_pkg, dpf_cell, dpf_div.
// Access: divide, scan, then on a fault a map into a free frame, or an evict and
// a map. Release: one table pass. Allocate: divide, a release pass, then per page
// a scan, an evict if needed, and a map. One item at a time; each table pass is
// one full revolution of the cell chain, one cell per cycle.
// Reset: all frames free, totals zero, frame_size 16, frames_in_use 64.
// Writing frames_in_use runs one table pass before the next item.
module demand_paging_fifo_frame_manager #(
	parameter int FRAMES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// config port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// request beat
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [15:0] pid,
	input  logic [16:0] mem_size,
	input  logic [15:0] address,
	// result beat
	output logic        out_valid,
	input  logic        out_ready,
	output logic        status,
	output logic [5:0]  frame,
	output logic        fault,
	output logic [16:0] evictions,
	output logic [15:0] victim_pid,
	output logic [15:0] victim_page,
	output logic [31:0] page_ins,
	output logic [31:0] page_outs,
	output logic [6:0]  frames_used,
	output logic [15:0] read_data
);
	import dpf_pkg::*;

	localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int RW = $clog2(FRAMES + 1);
	localparam int LW = (RW > 7) ? RW : 7;
	localparam logic [IW-1:0] LAST = IW'(FRAMES - 1);

	typedef enum logic [2:0] {
		S_IDLE, S_DIV, S_REL, S_SCAN, S_EVICT, S_MAP, S_DONE, S_SHRINK
	} state_t;

	state_t state_q;

	// config
	logic [16:0] fsize_q;
	logic [6:0]  frames_q;
	logic        shrink_q;
	logic        cfg_wr;
	logic [LW-1:0] lim;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_FRAMES) ? 32'(frames_q) : 32'(fsize_q);
	assign lim = (LW'(frames_q) > LW'(FRAMES)) ? LW'(FRAMES) : LW'(frames_q);

	// item context
	dpf_kind_t     kind_q;
	logic [15:0]   pid_q, page_q;
	logic [16:0]   n_q, i_q;
	logic [IW-1:0] cnt_q, f_q, hit_tag_q, free_tag_q, old_tag_q;
	logic          hit_q, free_found_q, old_found_q;
	logic [15:0]   old_owner_q, old_vpage_q;
	logic [RW-1:0] occ_q;
	logic          st_q, flt_q;
	logic [5:0]    frm_q;
	logic [16:0]   ev_q;
	logic [15:0]   vpid_q, vpg_q;
	logic [31:0]   pin_q, pout_q;

	// result register
	logic        ov_q, o_st_q, o_flt_q;
	logic [5:0]  o_frm_q;
	logic [16:0] o_ev_q;
	logic [15:0] o_vpid_q, o_vpg_q;
	logic [31:0] o_pin_q, o_pout_q;
	logic [6:0]  o_used_q;

	// divider
	logic        div_start, div_done;
	logic [16:0] div_dvd, div_dsr, div_quo, div_rem, msize_c;

	assign msize_c = (mem_size > MSIZE_MAX) ? MSIZE_MAX : mem_size;
	assign div_start = in_valid && in_ready && (kind != KIND_RELEASE);
	assign div_dvd = (kind == KIND_ALLOC) ? msize_c : 17'(address);
	assign div_dsr = (fsize_q == '0) ? 17'd1 : fsize_q;

	dpf_div u_div (
		.clk, .arst_n, .start(div_start), .dividend(div_dvd), .divisor(div_dsr),
		.done(div_done), .quo(div_quo), .rem(div_rem)
	);

	// cell chain; cell 0 is the head examined during a pass
	logic          c_busy [FRAMES];
	logic [IW-1:0] c_tag  [FRAMES];
	logic [15:0]   c_own  [FRAMES];
	logic [15:0]   c_vpg  [FRAMES];
	logic [RW-1:0] c_rank [FRAMES];

	logic          shift;
	dpf_cmd_t      cmd;
	logic [IW-1:0] free_tag, map_tag;
	logic [RW-1:0] free_rank;

	genvar g;
	generate
		for (g = 0; g < FRAMES; g++) begin : g_cell
			dpf_cell #(.IW(IW), .RW(RW), .RESET_TAG(g)) u_cell (
				.clk, .arst_n, .shift,
				.nb_busy (c_busy[(g + 1) % FRAMES]),
				.nb_tag  (c_tag [(g + 1) % FRAMES]),
				.nb_owner(c_own [(g + 1) % FRAMES]),
				.nb_vpage(c_vpg [(g + 1) % FRAMES]),
				.nb_rank (c_rank[(g + 1) % FRAMES]),
				.cmd, .free_tag, .free_rank, .map_tag, .map_rank(occ_q),
				.busy(c_busy[g]), .tag(c_tag[g]), .owner(c_own[g]),
				.vpage(c_vpg[g]), .rank(c_rank[g])
			);
		end
	endgenerate

	logic h_in_lim, h_hit, h_free, h_old, h_rel, h_cut;
	logic hit_n, free_n, old_n;
	logic [IW-1:0] hit_tag_n, free_tag_n, old_tag_n;
	logic [15:0] old_owner_n, old_vpage_n;

	assign h_in_lim = LW'(c_tag[0]) < lim;
	assign h_hit  = c_busy[0] && c_own[0] == pid_q && c_vpg[0] == page_q && h_in_lim;
	assign h_free = !c_busy[0] && h_in_lim;
	assign h_old  = c_busy[0] && c_rank[0] == '0 && h_in_lim;
	assign h_rel  = c_busy[0] && c_own[0] == pid_q;
	assign h_cut  = c_busy[0] && !h_in_lim;

	always_comb begin
		hit_n = hit_q;             hit_tag_n = hit_tag_q;
		free_n = free_found_q;     free_tag_n = free_tag_q;
		old_n = old_found_q;       old_tag_n = old_tag_q;
		old_owner_n = old_owner_q; old_vpage_n = old_vpage_q;
		if (!hit_q && h_hit) begin
			hit_n = 1'b1;
			hit_tag_n = c_tag[0];
		end
		if (!free_found_q && h_free) begin
			free_n = 1'b1;
			free_tag_n = c_tag[0];
		end
		if (h_old) begin
			old_n = 1'b1;
			old_tag_n = c_tag[0];
			old_owner_n = c_own[0];
			old_vpage_n = c_vpg[0];
		end
	end

	always_comb begin
		shift = (state_q == S_REL) || (state_q == S_SCAN) || (state_q == S_SHRINK);
		cmd.free_en = ((state_q == S_REL) && h_rel) || ((state_q == S_SHRINK) && h_cut)
			|| (state_q == S_EVICT);
		cmd.map_en = (state_q == S_MAP);
		cmd.owner  = pid_q;
		cmd.vpage  = (kind_q == KIND_ALLOC) ? i_q[15:0] : page_q;
		free_tag   = (state_q == S_EVICT) ? old_tag_q : c_tag[0];
		free_rank  = (state_q == S_EVICT) ? '0 : c_rank[0];
		map_tag    = f_q;
	end

	assign in_ready = (state_q == S_IDLE) && !shrink_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			fsize_q  <= FSIZE_RESET;
			frames_q <= FRAMES_RESET;
			shrink_q <= 1'b0;
			occ_q    <= '0;
			pin_q    <= '0;
			pout_q   <= '0;
			ov_q     <= 1'b0;
		end else begin
			if (cfg_wr) begin
				if (paddr[2] == REG_FRAMES) begin
					frames_q <= pwdata[6:0];
					shrink_q <= 1'b1;
				end else begin
					fsize_q <= pwdata[16:0];
				end
			end
			// S_DONE owns the result register while it is loading
			if (ov_q && out_ready && state_q != S_DONE) ov_q <= 1'b0;
			if (cmd.free_en) occ_q <= occ_q - 1'b1;
			case (state_q)
				S_IDLE: begin
					if (shrink_q) begin
						if (!(cfg_wr && paddr[2] == REG_FRAMES)) shrink_q <= 1'b0;
						cnt_q   <= '0;
						state_q <= S_SHRINK;
					end else if (in_valid) begin
						kind_q <= dpf_kind_t'(kind);
						pid_q  <= pid;
						st_q <= 1'b0; flt_q <= 1'b0; frm_q <= '0;
						ev_q <= '0; vpid_q <= '0; vpg_q <= '0;
						i_q <= '0; cnt_q <= '0;
						state_q <= (kind == KIND_RELEASE) ? S_REL : S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						n_q    <= div_quo + 17'(div_rem != '0);
						page_q <= div_quo[15:0];
						cnt_q  <= '0;
						hit_q <= 1'b0; free_found_q <= 1'b0; old_found_q <= 1'b0;
						state_q <= (kind_q == KIND_ALLOC) ? S_REL : S_SCAN;
					end
				end
				S_REL, S_SHRINK: begin
					if (cnt_q == LAST) begin
						cnt_q <= '0;
						hit_q <= 1'b0; free_found_q <= 1'b0; old_found_q <= 1'b0;
						if (state_q == S_SHRINK || kind_q == KIND_RELEASE || n_q == '0)
							state_q <= (state_q == S_SHRINK) ? S_IDLE : S_DONE;
						else
							state_q <= S_SCAN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_SCAN: begin
					hit_q <= hit_n; hit_tag_q <= hit_tag_n;
					free_found_q <= free_n; free_tag_q <= free_tag_n;
					old_found_q <= old_n; old_tag_q <= old_tag_n;
					old_owner_q <= old_owner_n; old_vpage_q <= old_vpage_n;
					if (cnt_q == LAST) begin
						cnt_q <= '0;
						if (kind_q != KIND_ALLOC && hit_n) begin
							frm_q   <= 6'(hit_tag_n);
							state_q <= S_DONE;
						end else begin
							if (kind_q != KIND_ALLOC) flt_q <= 1'b1;
							if (free_n) begin
								f_q     <= free_tag_n;
								state_q <= S_MAP;
							end else if (old_n) begin
								f_q     <= old_tag_n;
								state_q <= S_EVICT;
							end else begin
								st_q    <= 1'b1;
								frm_q   <= '0;
								state_q <= S_DONE;
							end
						end
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_EVICT: begin
					ev_q   <= ev_q + 1'b1;
					vpid_q <= old_owner_q;
					vpg_q  <= old_vpage_q;
					if (kind_q == KIND_ALLOC) pout_q <= pout_q + 1'b1;
					state_q <= S_MAP;
				end
				S_MAP: begin
					occ_q <= occ_q + 1'b1;
					frm_q <= 6'(f_q);
					hit_q <= 1'b0; free_found_q <= 1'b0; old_found_q <= 1'b0;
					if (kind_q == KIND_ALLOC) begin
						pin_q <= pin_q + 1'b1;
						i_q   <= i_q + 1'b1;
						state_q <= (i_q + 1'b1 == n_q) ? S_DONE : S_SCAN;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!ov_q || out_ready) begin
						ov_q     <= 1'b1;
						o_st_q   <= st_q;
						o_frm_q  <= frm_q;
						o_flt_q  <= flt_q;
						o_ev_q   <= ev_q;
						o_vpid_q <= vpid_q;
						o_vpg_q  <= vpg_q;
						o_pin_q  <= pin_q;
						o_pout_q <= pout_q;
						o_used_q <= 7'(occ_q);
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid   = ov_q;
	assign status      = o_st_q;
	assign frame       = o_frm_q;
	assign fault       = o_flt_q;
	assign evictions   = o_ev_q;
	assign victim_pid  = o_vpid_q;
	assign victim_page = o_vpg_q;
	assign page_ins    = o_pin_q;
	assign page_outs   = o_pout_q;
	assign frames_used = o_used_q;
	assign read_data   = '0;

endmodule

// ----- tb/demand_paging_fifo_frame_manager_test.sv -----
// Self-checking bench for the FIFO-replacement frame manager: directed table, then random phases.
// Uses dpf_pkg and the top module demand_paging_fifo_frame_manager; nothing else.
module demand_paging_fifo_frame_manager_test;
	import dpf_pkg::*;

	localparam int NF = 64;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        psel = 0, penable = 0, pwrite = 0;
	logic [2:0]  paddr = 0;
	logic [31:0] pwdata = 0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 0, in_ready;
	logic [1:0]  kind = 0;
	logic [15:0] pid = 0;
	logic [16:0] mem_size = 0;
	logic [15:0] address = 0;
	logic        out_valid, out_ready = 0;
	logic        status, fault;
	logic [5:0]  frame;
	logic [16:0] evictions;
	logic [15:0] victim_pid, victim_page, read_data;
	logic [31:0] page_ins, page_outs;
	logic [6:0]  frames_used;

	demand_paging_fifo_frame_manager #(.FRAMES(NF)) i_dut (.*);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	typedef struct packed {
		logic        status;
		logic [5:0]  frame;
		logic        fault;
		logic [16:0] evictions;
		logic [15:0] victim_pid;
		logic [15:0] victim_page;
		logic [31:0] page_ins;
		logic [31:0] page_outs;
		logic [6:0]  frames_used;
		logic [15:0] read_data;
	} mapping_result_t;

	mapping_result_t pending_results[$];
	int errors = 0;
	bit long_hold_req = 0;

	// ---- shadow frame table ----
	bit          sh_busy[NF];
	logic [15:0] sh_owner[NF];
	logic [15:0] sh_vpage[NF];
	int          sh_rank[NF];
	int          sh_occ;
	logic [31:0] sh_pins, sh_pouts;
	int          sh_fsize, sh_nframes;
	int          sh_evict;
	logic [15:0] sh_vpid, sh_vpg;

	function automatic int frame_limit();
		return sh_nframes > NF ? NF : sh_nframes;
	endfunction

	function automatic void unmap_frame(int f);
		int r;
		if (!sh_busy[f]) return;
		r = sh_rank[f];
		sh_busy[f] = 0;
		for (int j = 0; j < NF; j++)
			if (sh_busy[j] && sh_rank[j] > r) sh_rank[j]--;
		sh_occ--;
	endfunction

	function automatic void map_page(int f, logic [15:0] p, logic [15:0] vp);
		sh_busy[f] = 1;
		sh_owner[f] = p;
		sh_vpage[f] = vp;
		sh_rank[f] = sh_occ;
		sh_occ++;
	endfunction

	// lowest free frame, else evict the oldest; -1 if nothing usable
	function automatic int claim_frame();
		int lim, best;
		bit found;
		lim = frame_limit();
		best = 0;
		found = 0;
		for (int i = 0; i < lim; i++)
			if (!sh_busy[i]) return i;
		for (int i = 0; i < lim; i++)
			if (sh_busy[i] && (!found || sh_rank[i] < sh_rank[best])) begin
				best = i;
				found = 1;
			end
		if (!found) return -1;
		sh_vpid = sh_owner[best];
		sh_vpg = sh_vpage[best];
		sh_evict++;
		unmap_frame(best);
		return best;
	endfunction

	function automatic void release_owner(logic [15:0] p);
		for (int i = 0; i < NF; i++)
			if (sh_busy[i] && sh_owner[i] == p) unmap_frame(i);
	endfunction

	function automatic void apply_reg(logic rsel, logic [31:0] v);
		if (rsel == REG_FRAME_SIZE) begin
			sh_fsize = v & 32'h1FFFF;
		end else begin
			sh_nframes = v & 32'h7F;
			for (int i = frame_limit(); i < NF; i++) unmap_frame(i);
		end
	endfunction

	function automatic mapping_result_t predict_mapping(dpf_kind_t k, logic [15:0] p,
			logic [16:0] ms, logic [15:0] ad);
		mapping_result_t r;
		int fs, n, f, prev_ev, lim, msz;
		logic [15:0] pg;
		bit hit;
		r = '0;
		fs = sh_fsize == 0 ? 1 : sh_fsize;
		sh_evict = 0;
		sh_vpid = 0;
		sh_vpg = 0;
		case (k)
			KIND_ALLOC: begin
				msz = ms > MSIZE_MAX ? MSIZE_MAX : ms;
				n = msz / fs + ((msz % fs) != 0);
				release_owner(p);
				for (int i = 0; i < n; i++) begin
					prev_ev = sh_evict;
					f = claim_frame();
					if (f < 0) begin
						r.status = 1;
						r.frame = 0;
						break;
					end
					if (sh_evict != prev_ev) sh_pouts++;
					map_page(f, p, i[15:0]);
					sh_pins++;
					r.frame = f[5:0];
				end
			end
			KIND_RELEASE: release_owner(p);
			default: begin
				pg = 16'(ad / fs);
				lim = frame_limit();
				hit = 0;
				for (int i = 0; i < lim; i++)
					if (sh_busy[i] && sh_owner[i] == p && sh_vpage[i] == pg) begin
						r.frame = i[5:0];
						hit = 1;
						break;
					end
				if (!hit) begin
					r.fault = 1;
					f = claim_frame();
					if (f < 0) r.status = 1;
					else begin
						map_page(f, p, pg);
						r.frame = f[5:0];
					end
				end
			end
		endcase
		r.evictions = sh_evict[16:0];
		r.victim_pid = sh_vpid;
		r.victim_page = sh_vpg;
		r.page_ins = sh_pins;
		r.page_outs = sh_pouts;
		r.frames_used = sh_occ[6:0];
		r.read_data = 0;
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d, expected %0d", what, got, want);
		errors++;
	endtask

	// ---- result monitor ----
	always @(posedge clk) begin
		mapping_result_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected beat", 1, 0);
			end else begin
				e = pending_results[0];
				pending_results.delete(0);
				if (status != e.status) report_mismatch("status", status, e.status);
				if (frame != e.frame) report_mismatch("frame", frame, e.frame);
				if (fault != e.fault) report_mismatch("fault", fault, e.fault);
				if (evictions != e.evictions)
					report_mismatch("evictions", evictions, e.evictions);
				if (victim_pid != e.victim_pid)
					report_mismatch("victim_pid", victim_pid, e.victim_pid);
				if (victim_page != e.victim_page)
					report_mismatch("victim_page", victim_page, e.victim_page);
				if (page_ins != e.page_ins) report_mismatch("page_ins", page_ins, e.page_ins);
				if (page_outs != e.page_outs)
					report_mismatch("page_outs", page_outs, e.page_outs);
				if (frames_used != e.frames_used)
					report_mismatch("frames_used", frames_used, e.frames_used);
				if (read_data != e.read_data)
					report_mismatch("read_data", read_data, e.read_data);
			end
		end
	end

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		int c;
		c = $urandom_range(0, 99);
		if (c < 65) return 0;
		if (c < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// ---- receiver: random stalls, plus one long hold on request ----
	initial begin
		int g;
		forever begin
			if (long_hold_req) begin
				long_hold_req = 0;
				out_ready <= 0;
				repeat (400) @(posedge clk);
			end else begin
				g = gap_len();
				if (g == 0) begin
					out_ready <= 1;
					@(posedge clk);
				end else begin
					out_ready <= 0;
					repeat (g) @(posedge clk);
				end
			end
		end
	end

	task automatic wait_drained();
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write happens at the access-phase edge; block must be idle.
	task automatic write_reg(logic rsel, logic [31:0] v);
		in_valid <= 0;
		wait_drained();
		// a frame-count shrink pass may still be running
		while (!in_ready) @(posedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {rsel, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		apply_reg(rsel, v);
	endtask

	// One request beat; typed fields, when given, replace the predicted ones.
	task automatic send_request(dpf_kind_t k, logic [15:0] p, logic [16:0] ms,
			logic [15:0] ad, bit typed = 0, logic est = 0, logic [5:0] efr = 0,
			logic [6:0] eused = 0);
		int g;
		mapping_result_t r;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1;
		kind <= k;
		pid <= p;
		mem_size <= ms;
		address <= ad;
		do @(posedge clk); while (!in_ready);
		r = predict_mapping(k, p, ms, ad);
		if (typed) begin
			r.status = est;
			r.frame = efr;
			r.frames_used = eused;
		end
		pending_results.insert(pending_results.size(), r);
	endtask

	typedef struct {
		bit          is_cfg;
		logic        rsel;
		logic [31:0] val;
		dpf_kind_t   k;
		logic [15:0] p;
		logic [16:0] ms;
		logic [15:0] ad;
		bit          typed;
		logic        est;
		logic [5:0]  efr;
		logic [6:0]  eused;
	} step_row_t;

	// Directed: reset state, hits and misses, self eviction, zero frames,
	// oversized frame count, zero/huge frame size, oversized request.
	step_row_t directed[] = '{
		'{0, 0, 0, KIND_ALLOC,   16'd1,    17'd16,     16'd0,    1, 0, 0,  1},
		'{0, 0, 0, KIND_ALLOC,   16'd1,    17'd0,      16'd0,    1, 0, 0,  0},
		'{0, 0, 0, KIND_READ,    16'd2,    17'd0,      16'hFFFF, 1, 0, 0,  1},
		'{0, 0, 0, KIND_WRITE,   16'd2,    17'h1FFFF,  16'hFFFF, 1, 0, 0,  1},
		'{0, 0, 0, KIND_RELEASE, 16'hFFFF, 17'd0,      16'd0,    1, 0, 0,  1},
		'{0, 0, 0, KIND_RELEASE, 16'd2,    17'd0,      16'd0,    1, 0, 0,  0},
		'{1, REG_FRAMES, 2, KIND_ALLOC, 0, 0, 0, 0, 0, 0, 0},
		'{0, 0, 0, KIND_ALLOC,   16'd3,    17'd80,     16'd0,    0, 0, 0,  0},
		'{0, 0, 0, KIND_READ,    16'd3,    17'd0,      16'd0,    0, 0, 0,  0},
		'{1, REG_FRAMES, 0, KIND_ALLOC, 0, 0, 0, 0, 0, 0, 0},
		'{0, 0, 0, KIND_READ,    16'd4,    17'd0,      16'd5,    1, 1, 0,  0},
		'{0, 0, 0, KIND_ALLOC,   16'd4,    17'd32,     16'd0,    1, 1, 0,  0},
		'{0, 0, 0, KIND_ALLOC,   16'd4,    17'd0,      16'd0,    1, 0, 0,  0},
		'{1, REG_FRAMES, 100, KIND_ALLOC, 0, 0, 0, 0, 0, 0, 0},
		'{1, REG_FRAME_SIZE, 0, KIND_ALLOC, 0, 0, 0, 0, 0, 0, 0},
		'{0, 0, 0, KIND_ALLOC,   16'd5,    17'd3,      16'd0,    1, 0, 2,  3},
		'{0, 0, 0, KIND_WRITE,   16'd5,    17'd0,      16'd2,    1, 0, 2,  3},
		'{1, REG_FRAME_SIZE, 131071, KIND_ALLOC, 0, 0, 0, 0, 0, 0, 0},
		'{0, 0, 0, KIND_WRITE,   16'd5,    17'd0,      16'hFFFF, 1, 0, 0,  3},
		'{0, 0, 0, KIND_ALLOC,   16'd6,    17'h1FFFF,  16'd0,    1, 0, 3,  4},
		'{1, REG_FRAME_SIZE, 65536, KIND_ALLOC, 0, 0, 0, 0, 0, 0, 0},
		'{0, 0, 0, KIND_ALLOC,   16'd7,    17'd65536,  16'd0,    1, 0, 4,  5},
		'{1, REG_FRAME_SIZE, 4096, KIND_ALLOC, 0, 0, 0, 0, 0, 0, 0},
		'{0, 0, 0, KIND_ALLOC,   16'd8,    17'd65536,  16'd0,    1, 0, 20, 21},
		'{0, 0, 0, KIND_READ,    16'd0,    17'd0,      16'd0,    0, 0, 0,  0},
		'{1, REG_FRAMES, 64, KIND_ALLOC, 0, 0, 0, 0, 0, 0, 0},
		'{1, REG_FRAME_SIZE, 16, KIND_ALLOC, 0, 0, 0, 0, 0, 0, 0}
	};

	function automatic logic [15:0] pick_pid();
		int c;
		c = $urandom_range(0, 9);
		if (c < 8) return $urandom_range(0, 5);
		if (c == 8) return 16'hFFFF - $urandom_range(0, 2);
		return $urandom;
	endfunction

	// ---- stimulus ----
	initial begin
		int fs;
		longint v;
		dpf_kind_t k;
		logic [16:0] mem_size_tmp;
		for (int i = 0; i < NF; i++) begin
			sh_busy[i] = 0;
			sh_owner[i] = 0;
			sh_vpage[i] = 0;
			sh_rank[i] = 0;
		end
		sh_occ = 0;
		sh_pins = 0;
		sh_pouts = 0;
		sh_fsize = FSIZE_RESET;
		sh_nframes = FRAMES_RESET;

		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		foreach (directed[i]) begin
			if (directed[i].is_cfg) write_reg(directed[i].rsel, directed[i].val);
			else send_request(directed[i].k, directed[i].p, directed[i].ms, directed[i].ad,
				directed[i].typed, directed[i].est, directed[i].efr, directed[i].eused);
		end

		for (int ph = 0; ph < 10; ph++) begin
			case ($urandom_range(0, 3))
				0: write_reg(REG_FRAME_SIZE, $urandom_range(1, 16));
				1: write_reg(REG_FRAME_SIZE, $urandom_range(17, 512));
				2: write_reg(REG_FRAME_SIZE, $urandom_range(8192, 131071));
				default: write_reg(REG_FRAME_SIZE, ph[0] ? 0 : 131071);
			endcase
			case ($urandom_range(0, 3))
				0: write_reg(REG_FRAMES, $urandom_range(1, 8));
				1: write_reg(REG_FRAMES, $urandom_range(9, 64));
				2: write_reg(REG_FRAMES, 64);
				default: write_reg(REG_FRAMES, $urandom_range(0, 127));
			endcase
			fs = sh_fsize == 0 ? 1 : sh_fsize;
			if (ph == 3) long_hold_req = 1;
			for (int n = 0; n < 123; n++) begin
				// sender stops until the block is fully drained
				if (ph == 6 && n == 60) begin
					in_valid <= 0;
					wait_drained();
				end
				k = dpf_kind_t'($urandom_range(0, 3));
				if (fs >= 8192 && $urandom_range(0, 2) == 0) begin
					v = $urandom_range(0, 131071);
				end else begin
					v = longint'($urandom_range(0, 8)) * fs;
					if (v > 0) v -= $urandom_range(0, fs - 1);
					if (v > 131071) v = 131071;
				end
				mem_size_tmp = v[16:0];
				v = longint'($urandom_range(0, 9)) * fs + $urandom_range(0, fs - 1);
				if (v > 65535 || $urandom_range(0, 4) == 0) v = $urandom_range(0, 65535);
				send_request(k, pick_pid(), mem_size_tmp, v[15:0]);
			end
		end
		in_valid <= 0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0) $display("Verification passed");
		else $display("Verification failed");
		$finish;
	end

	initial begin
		#40000000;
		$display("Verification failed");
		$finish;
	end

endmodule
